/* rtl/core/text_whitespace_normalizer_defines.svh */
// Assertion macros used by the checker of the whitespace normalizer.
`ifndef TEXT_WHITESPACE_NORMALIZER_DEFINES_SVH
`define TEXT_WHITESPACE_NORMALIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("twn check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TWN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("twn check failed");

`endif

/* rtl/core/twn_pkg.sv */
package twn_pkg;

	localparam int MAX_HELD_PAIRS = 16;
	localparam int PAIR_W         = 5;
	localparam int NL_W           = PAIR_W + 1;
	localparam int Q_DEPTH        = 4;
	localparam int Q_AW           = 2;
	localparam int Q_CW           = 3;

	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_N       = 8'h6E;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_ch;
		logic       has_char;
		logic       end_of_block;
	} out_t;

	// One classified byte: released held output, then up to two new bytes.
	typedef struct packed {
		logic            esc;
		logic [7:0]      esc_byte;
		logic            sp;
		logic [NL_W-1:0] nl;
		logic [1:0]      nb;
		logic [7:0]      b0;
		logic [7:0]      b1;
		logic            last;
	} cmd_t;

endpackage

/* rtl/core/text_whitespace_normalizer.sv */
// Channel  | Direction | Payload (twn_pkg)                 | Handshake
// ---------+-----------+-----------------------------------+--------------------------
// text     | in        | in_t  {ch, last}                  | text_valid / text_stall
// norm     | out       | out_t {out_ch, has_char, end_...} | norm_valid / norm_stall
//
// One text byte is taken per cycle while the four-entry command queue has room.
// A byte that releases held output becomes a burst of up to 4 + 2*MAX_HELD_PAIRS
// results, which the back end sends one per cycle while norm_stall is low.
// text_stall rises only when the queue is full, so bursts back up into the input.
// arst_n clears the scanner, the held output, the queue pointers and the output valid.
// norm_stall holds the output register; the front keeps accepting until the queue fills.
module text_whitespace_normalizer
	import twn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic text_valid,
	input  in_t  text,
	output logic text_stall,
	output logic norm_valid,
	output out_t norm,
	input  logic norm_stall
);

	cmd_t push_cmd, head;
	logic push, pop, q_empty, q_full;

	// Classify each transfer and track held whitespace.
	twn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text       (text),
		.text_stall (text_stall),
		.q_full     (q_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	// Decouple the scanner from the output drain.
	twn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// Expand each command into result transfers, one per cycle unless norm_stall holds the output.
	twn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.norm_valid (norm_valid),
		.norm       (norm),
		.norm_stall (norm_stall)
	);

endmodule

/* rtl/core/twn_front.sv */
module twn_front
	import twn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic text_valid,
	input  in_t  text,
	output logic text_stall,
	input  logic q_full,
	output logic push,
	output cmd_t cmd
);

	localparam logic [2:0] ST_START   = 3'd0;
	localparam logic [2:0] ST_TEXT    = 3'd1;
	localparam logic [2:0] ST_SPACE   = 3'd2;
	localparam logic [2:0] ST_LINE    = 3'd3;
	localparam logic [2:0] ST_LINE_SP = 3'd4;
	localparam logic [2:0] ST_DOUBLE  = 3'd5;
	localparam logic [2:0] ST_ESCAPE  = 3'd6;

	logic [2:0]        state_q, n_state;
	logic              hev_q, n_hev;
	logic [7:0]        heb_q, n_heb;
	logic              hs_q, n_hs;
	logic [PAIR_W-1:0] pairs_q, n_pairs;
	logic              accept, blank, ws, any_out;
	logic [7:0]        c;

	assign text_stall = q_full;
	assign accept     = text_valid && !q_full;
	assign c          = text.ch;

	always_comb begin
		blank   = (c == CH_SPACE) || (c == CH_TAB);
		ws      = blank || (c == CH_CR) || (c == CH_LF);
		cmd      = '0;
		cmd.last = text.last;
		n_state = state_q;
		n_hev   = hev_q;
		n_heb   = heb_q;
		n_hs    = hs_q;
		n_pairs = pairs_q;
		// release held output ahead of any visible byte
		if (!ws) begin
			cmd.esc      = hev_q;
			cmd.esc_byte = heb_q;
			cmd.sp       = hs_q;
			cmd.nl       = {pairs_q, 1'b0};
			n_hev   = 1'b0;
			n_heb   = '0;
			n_hs    = 1'b0;
			n_pairs = '0;
		end
		unique case (state_q)
			ST_TEXT: begin
				if (blank) begin
					n_hs    = 1'b1;
					n_state = ST_SPACE;
				end else if (c == CH_CR) begin
				end else if (c == CH_LF) begin
					n_state = ST_LINE;
				end else if (c == CH_BSLASH) begin
					n_state = ST_ESCAPE;
				end else begin
					cmd.nb = 2'd1;
					cmd.b0 = c;
				end
			end
			ST_SPACE: begin
				if (blank || c == CH_CR) begin
				end else if (c == CH_LF) begin
					n_state = ST_LINE_SP;
				end else if (c == CH_BSLASH) begin
					n_state = ST_ESCAPE;
				end else begin
					cmd.nb  = 2'd1;
					cmd.b0  = c;
					n_state = ST_TEXT;
				end
			end
			ST_LINE, ST_LINE_SP: begin
				if (blank || c == CH_CR) begin
				end else if (c == CH_LF) begin
					if (pairs_q < PAIR_W'(MAX_HELD_PAIRS)) begin
						n_pairs = pairs_q + PAIR_W'(1);
					end
					n_state = ST_DOUBLE;
				end else if (c == CH_BSLASH) begin
					// a lone line break joins with a space
					if (state_q == ST_LINE) begin
						cmd.nb = 2'd1;
						cmd.b0 = CH_SPACE;
					end
					n_state = ST_ESCAPE;
				end else begin
					if (state_q == ST_LINE) begin
						cmd.nb = 2'd2;
						cmd.b0 = CH_SPACE;
						cmd.b1 = c;
					end else begin
						cmd.nb = 2'd1;
						cmd.b0 = c;
					end
					n_state = ST_TEXT;
				end
			end
			ST_DOUBLE: begin
				if (blank) begin
					n_state = ST_SPACE;
				end else if (c == CH_CR || c == CH_LF) begin
				end else if (c == CH_BSLASH) begin
					n_state = ST_ESCAPE;
				end else begin
					cmd.nb  = 2'd1;
					cmd.b0  = c;
					n_state = ST_TEXT;
				end
			end
			ST_ESCAPE: begin
				if (c == CH_BSLASH) begin
					cmd.nb  = 2'd1;
					cmd.b0  = CH_BSLASH;
					n_state = ST_TEXT;
				end else if (c == CH_N) begin
					cmd.nb  = 2'd1;
					cmd.b0  = CH_LF;
					n_state = ST_DOUBLE;
				end else if (c == CH_PERCENT) begin
					cmd.nb  = 2'd2;
					cmd.b0  = CH_PERCENT;
					cmd.b1  = CH_PERCENT;
					n_state = ST_TEXT;
				end else begin
					// hold an escaped whitespace byte until text follows
					if (ws) begin
						n_hev = 1'b1;
						n_heb = c;
					end else begin
						cmd.nb = 2'd1;
						cmd.b0 = c;
					end
					n_state = ST_TEXT;
				end
			end
			default: begin
				if (c == CH_BSLASH) begin
					n_state = ST_ESCAPE;
				end else if (!ws) begin
					cmd.nb  = 2'd1;
					cmd.b0  = c;
					n_state = ST_TEXT;
				end
			end
		endcase
		if (text.last) begin
			n_state = ST_START;
			n_hev   = 1'b0;
			n_heb   = '0;
			n_hs    = 1'b0;
			n_pairs = '0;
		end
		any_out = cmd.esc || cmd.sp || (cmd.nl != '0) || (cmd.nb != 2'd0);
		push    = accept && (any_out || text.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			hev_q   <= 1'b0;
			heb_q   <= '0;
			hs_q    <= 1'b0;
			pairs_q <= '0;
		end else if (accept) begin
			state_q <= n_state;
			hev_q   <= n_hev;
			heb_q   <= n_heb;
			hs_q    <= n_hs;
			pairs_q <= n_pairs;
		end
	end

endmodule

/* rtl/core/twn_queue.sv */
module twn_queue
	import twn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == Q_CW'(Q_DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + Q_CW'(1);
				2'b01:   cnt_q <= cnt_q - Q_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/core/twn_back.sv */
module twn_back
	import twn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t head,
	input  logic q_empty,
	output logic pop,
	output logic norm_valid,
	output out_t norm,
	input  logic norm_stall
);

	cmd_t cur_q, src, rem;
	logic cur_act_q, adv, src_valid, rem_empty;
	out_t pick;

	assign adv       = !norm_valid || !norm_stall;
	assign src       = cur_act_q ? cur_q : head;
	assign src_valid = cur_act_q || !q_empty;
	assign pop       = adv && !cur_act_q && !q_empty;

	// release order: escape byte, space, newlines, new bytes, bare marker
	always_comb begin
		rem  = src;
		pick = '0;
		priority if (src.esc) begin
			pick.out_ch   = src.esc_byte;
			pick.has_char = 1'b1;
			rem.esc       = 1'b0;
		end else if (src.sp) begin
			pick.out_ch   = CH_SPACE;
			pick.has_char = 1'b1;
			rem.sp        = 1'b0;
		end else if (src.nl != '0) begin
			pick.out_ch   = CH_LF;
			pick.has_char = 1'b1;
			rem.nl        = src.nl - NL_W'(1);
		end else if (src.nb != 2'd0) begin
			pick.out_ch   = src.b0;
			pick.has_char = 1'b1;
			rem.b0        = src.b1;
			rem.nb        = src.nb - 2'd1;
		end else begin
			pick.out_ch   = '0;
			pick.has_char = 1'b0;
		end
		rem_empty = !rem.esc && !rem.sp && (rem.nl == '0) && (rem.nb == 2'd0);
		pick.end_of_block = src.last && rem_empty;
	end

	always_ff @(posedge clk) begin
		if (adv && src_valid) begin
			norm  <= pick;
			cur_q <= rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_valid <= 1'b0;
			cur_act_q  <= 1'b0;
		end else if (adv) begin
			norm_valid <= src_valid;
			if (src_valid) begin
				cur_act_q <= !rem_empty;
			end
		end
	end

endmodule

/* rtl/core/twn_checker.sv */
`include "text_whitespace_normalizer_defines.svh"

module twn_checker
	import twn_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic text_valid,
	input in_t  text,
	input logic text_stall,
	input logic norm_valid,
	input out_t norm,
	input logic norm_stall
);

	`TWN_ASSERT_NEXT(a_norm_hold, norm_valid && norm_stall, norm_valid && $stable(norm))
	`TWN_ASSERT_NOW(a_marker_ends, norm_valid && !norm.has_char, norm.end_of_block)
	`TWN_ASSERT_NOW(a_marker_zero, norm_valid && !norm.has_char, norm.out_ch == 8'h00)

endmodule

bind text_whitespace_normalizer twn_checker u_twn_checker (.*);

/* bench/text_whitespace_normalizer_tb.sv */
module text_whitespace_normalizer_tb;
	import twn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Cap on results per input byte; never exceeded while the pair bound is 16 or less.
	localparam int MAX_RESULTS = 36;
	// Watchdog bound in cycles, far beyond the slowest legal run.
	localparam int CYCLE_LIMIT = 200000;

	// Scanner states, in the encoding the block uses.
	typedef enum logic [2:0] {
		SCAN_START,
		SCAN_TEXT,
		SCAN_SPACE,
		SCAN_LINE,
		SCAN_LINE_SP,
		SCAN_DOUBLE,
		SCAN_ESCAPE
	} scan_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	in_t  text = '0;
	logic text_stall;
	logic norm_valid;
	out_t norm;
	logic norm_stall = 1'b0;

	// Suppress random idling on both channels while set.
	bit quiet = 1'b0;
	int mismatches = 0;
	int cycles = 0;

	// Results still owed by the block, oldest first.
	out_t expected_norm[$];

	// Shadow of the scanner and its held-back output.
	scan_e      scan_q = SCAN_START;
	logic       esc_held = 1'b0;
	logic [7:0] esc_byte = 8'h00;
	logic       space_held = 1'b0;
	logic [4:0] pairs_held = '0;

	text_whitespace_normalizer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text       (text),
		.text_stall (text_stall),
		.norm_valid (norm_valid),
		.norm       (norm),
		.norm_stall (norm_stall)
	);

	always #10 clk = ~clk;

	// Watchdog: abort the run with a failure once the total cycle count hits the limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver side: stall at random unless a quiet stretch is running.
	always @(posedge clk) begin
		norm_stall <= !quiet && ($urandom_range(0, 99) < 36);
	end

	// Queue one output byte, dropping anything past the per-byte cap.
	task automatic push_char(input logic [7:0] c, inout int n);
		if (n < MAX_RESULTS)
			expected_norm.push_back(out_t'{c, 1'b1, 1'b0});
		n++;
	endtask

	// Advance the shadow scanner by one accepted byte and queue what it releases.
	task automatic predict_norm(input in_t t);
		logic [7:0] c;
		logic       blank;
		logic       ws;
		int         n;
		out_t       tail;
		c = t.ch;
		blank = (c == CH_SPACE) || (c == CH_TAB);
		ws = blank || (c == CH_CR) || (c == CH_LF);
		n = 0;

		// A visible byte releases the held escape, then the space, then the pairs.
		if (!ws) begin
			if (esc_held)
				push_char(esc_byte, n);
			if (space_held)
				push_char(CH_SPACE, n);
			for (int k = 0; k < pairs_held; k++) begin
				push_char(CH_LF, n);
				push_char(CH_LF, n);
			end
			esc_held = 1'b0;
			esc_byte = 8'h00;
			space_held = 1'b0;
			pairs_held = '0;
		end

		case (scan_q)
			SCAN_TEXT: begin
				if (blank) begin
					space_held = 1'b1;
					scan_q = SCAN_SPACE;
				end else if (c == CH_LF)
					scan_q = SCAN_LINE;
				else if (c == CH_BSLASH)
					scan_q = SCAN_ESCAPE;
				else if (c != CH_CR)
					push_char(c, n);
			end
			SCAN_SPACE: begin
				if (c == CH_LF)
					scan_q = SCAN_LINE_SP;
				else if (c == CH_BSLASH)
					scan_q = SCAN_ESCAPE;
				else if (!ws) begin
					push_char(c, n);
					scan_q = SCAN_TEXT;
				end
			end
			SCAN_LINE, SCAN_LINE_SP: begin
				// A joined line gets a space unless one is already held.
				if (c == CH_LF) begin
					if (pairs_held < MAX_HELD_PAIRS)
						pairs_held++;
					scan_q = SCAN_DOUBLE;
				end else if (c == CH_BSLASH) begin
					if (scan_q == SCAN_LINE)
						push_char(CH_SPACE, n);
					scan_q = SCAN_ESCAPE;
				end else if (!ws) begin
					if (scan_q == SCAN_LINE)
						push_char(CH_SPACE, n);
					push_char(c, n);
					scan_q = SCAN_TEXT;
				end
			end
			SCAN_DOUBLE: begin
				if (blank)
					scan_q = SCAN_SPACE;
				else if (c == CH_BSLASH)
					scan_q = SCAN_ESCAPE;
				else if (!ws) begin
					push_char(c, n);
					scan_q = SCAN_TEXT;
				end
			end
			SCAN_ESCAPE: begin
				if (c == CH_BSLASH) begin
					push_char(CH_BSLASH, n);
					scan_q = SCAN_TEXT;
				end else if (c == CH_N) begin
					push_char(CH_LF, n);
					scan_q = SCAN_DOUBLE;
				end else if (c == CH_PERCENT) begin
					push_char(CH_PERCENT, n);
					push_char(CH_PERCENT, n);
					scan_q = SCAN_TEXT;
				end else begin
					// Hold an escaped whitespace byte like any other trailing whitespace.
					if (ws) begin
						esc_held = 1'b1;
						esc_byte = c;
					end else
						push_char(c, n);
					scan_q = SCAN_TEXT;
				end
			end
			default: begin
				// Start state: drop leading whitespace.
				if (c == CH_BSLASH)
					scan_q = SCAN_ESCAPE;
				else if (!ws) begin
					push_char(c, n);
					scan_q = SCAN_TEXT;
				end
			end
		endcase

		// End of block: mark the last result, or owe a bare marker, and drop held output.
		if (t.last) begin
			if (n == 0)
				expected_norm.push_back(out_t'{8'h00, 1'b0, 1'b1});
			else begin
				tail = expected_norm.pop_back();
				tail.end_of_block = 1'b1;
				expected_norm.push_back(tail);
			end
			scan_q = SCAN_START;
			esc_held = 1'b0;
			esc_byte = 8'h00;
			space_held = 1'b0;
			pairs_held = '0;
		end
	endtask

	// Sample both channels at the edge: predict on each input transfer,
	// check each output transfer against the oldest expectation.
	always @(posedge clk) begin : monitor
		out_t want;
		if (arst_n) begin
			if (text_valid && !text_stall)
				predict_norm(text);
			if (norm_valid && !norm_stall) begin
				if (expected_norm.size() == 0) begin
					mismatches++;
					if (mismatches <= 40)
						$display("%0t: expected none, actual %02h/%b/%b",
							$time, norm.out_ch, norm.has_char, norm.end_of_block);
				end else begin
					want = expected_norm.pop_front();
					if (norm.out_ch !== want.out_ch || norm.has_char !== want.has_char ||
						norm.end_of_block !== want.end_of_block) begin
						mismatches++;
						if (mismatches <= 40)
							$display("%0t: expected %02h/%b/%b, actual %02h/%b/%b",
								$time, want.out_ch, want.has_char, want.end_of_block,
								norm.out_ch, norm.has_char, norm.end_of_block);
					end
				end
			end
		end
	end

	// Offer one byte and hold it until the transfer completes.
	task automatic send_item(input logic [7:0] c, input logic fin);
		in_t item;
		item.ch = c;
		item.last = fin;
		while (!quiet && ($urandom_range(0, 99) < 36)) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid <= 1'b1;
		text <= item;
		do
			@(posedge clk);
		while (text_stall);
	endtask

	// Send a string byte by byte; flag the final byte when the block closes.
	task automatic send_text(input string s, input bit closes);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], closes && (i == s.len() - 1));
	endtask

	// Random visible byte: mostly printable, sometimes high, never a backslash.
	function automatic logic [7:0] word_byte();
		logic [7:0] c;
		if ($urandom_range(0, 9) == 0)
			c = 8'($urandom_range(8'h80, 8'hFF));
		else begin
			c = 8'($urandom_range(8'h21, 8'h7E));
			if (c == CH_BSLASH)
				c = 8'h5B;
		end
		return c;
	endfunction

	function automatic logic [7:0] ws_byte();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// Build one block from text-like tokens with some noise, then send it.
	task automatic send_random_block(input int target);
		logic [7:0] bytes_q[$];
		int pick;
		bytes_q = {};
		while (bytes_q.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				repeat ($urandom_range(1, 6))
					bytes_q.push_back(word_byte());
			end else if (pick < 58) begin
				repeat ($urandom_range(1, 3))
					bytes_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			end else if (pick < 70) begin
				if ($urandom_range(0, 1))
					bytes_q.push_back(CH_CR);
				bytes_q.push_back(CH_LF);
			end else if (pick < 78) begin
				bytes_q.push_back(CH_LF);
				if ($urandom_range(0, 1))
					bytes_q.push_back(CH_TAB);
				bytes_q.push_back(CH_LF);
			end else if (pick < 92) begin
				bytes_q.push_back(CH_BSLASH);
				case ($urandom_range(0, 4))
					0: bytes_q.push_back(CH_BSLASH);
					1: bytes_q.push_back(CH_N);
					2: bytes_q.push_back(CH_PERCENT);
					3: bytes_q.push_back(8'($urandom_range(0, 255)));
					default: bytes_q.push_back(ws_byte());
				endcase
			end else
				bytes_q.push_back(8'($urandom_range(0, 255)));
		end
		// Now and then cut the block off right after a backslash.
		if ($urandom_range(0, 9) == 0)
			bytes_q.push_back(CH_BSLASH);
		foreach (bytes_q[i])
			send_item(bytes_q[i], i == bytes_q.size() - 1);
	endtask

	// Drop valid and hold off until every owed result has been checked.
	task automatic drain_results();
		text_valid <= 1'b0;
		@(posedge clk);
		while (expected_norm.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_cases();
		// Leading whitespace, then the byte extremes.
		send_text("\tx", 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		// Blank run folds to one space; CR LF joins lines.
		send_text(" \t b\r\nc", 1'b0);
		// Blank line becomes a paragraph break.
		send_text("\n \r\nd", 1'b0);
		// Every escape form.
		send_text("\\\\\\n\\%\\q", 1'b0);
		// Escaped blank is held, released by f; trailing blank and break are trimmed,
		// so the final byte yields a bare end marker.
		send_text("\\ f \n", 1'b1);
		// Whitespace-only block, then a one-byte block.
		send_text(" ", 1'b1);
		send_text("g", 1'b1);
	endtask

	task automatic test_random_text();
		repeat (2)
			send_random_block($urandom_range(6, 20));
	endtask

	// Stack more blank lines than the pair counter holds, behind a held escape
	// and a held space, so the releasing byte produces a burst with the pair count saturated.
	task automatic test_break_saturation();
		int pairs;
		for (int b = 0; b < 2; b++) begin
			pairs = (b == 0) ? MAX_HELD_PAIRS + 1 : $urandom_range(2, 3);
			send_item(word_byte(), 1'b0);
			send_item(CH_BSLASH, 1'b0);
			send_item($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
			send_item(CH_SPACE, 1'b0);
			send_item(CH_LF, 1'b0);
			send_item(CH_LF, 1'b0);
			repeat (pairs - 1) begin
				send_item($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
				if ($urandom_range(0, 1))
					send_item(CH_CR, 1'b0);
				send_item(CH_LF, 1'b0);
				send_item(CH_LF, 1'b0);
			end
			send_item(word_byte(), 1'b1);
		end
	endtask

	// Pause the sender until the block has caught up, then resume.
	task automatic test_drain_pause();
		send_random_block(8);
		drain_results();
		send_random_block(8);
	endtask

	// Full rate on both sides: no random gaps, no receiver stalls.
	task automatic test_back_to_back();
		quiet = 1'b1;
		send_random_block(24);
		quiet = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_text();
		test_break_saturation();
		test_drain_pause();
		test_back_to_back();

		// Let the last results arrive, then allow for bytes still in the queue.
		drain_results();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_norm.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/twn_pkg.sv
rtl/core/twn_front.sv
rtl/core/twn_queue.sv
rtl/core/twn_back.sv
rtl/core/text_whitespace_normalizer.sv
rtl/core/twn_checker.sv
bench/text_whitespace_normalizer_tb.sv
